// ===== hdl/ht_pkg.sv =====
package ht_pkg;

    // Pixel and result formats
    localparam int IN_W     = 16;
    localparam int IN_FRAC  = 8;
    localparam int OUT_FRAC = 12;
    localparam int OUT_W    = OUT_FRAC + 1;

    // Configuration port
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int A_W     = IN_W + 9;         // 251x+768 and 243x+15104
    localparam int DIV_W   = 2 * IN_W + 10;    // numerator / denominator of the ratio
    localparam int RPROD_W = IN_W + GAIN_W;    // x * exposure
    localparam int YW      = RPROD_W - IN_FRAC;

    // Front end (3 stages) then one stage per quotient bit
    localparam int NSTAGE = 3 + OUT_FRAC;

    // ACES fit on raw Q8.8 codes: x(251x+768) / (x(243x+15104)+917504)
    localparam int ACES_NA = 251;
    localparam int ACES_NB = 3 * 256;
    localparam int ACES_DA = 243;
    localparam int ACES_DB = 59 * 256;
    localparam int ACES_DC = 14 * 65536;

    typedef enum logic [0:0] {
        MODE_ACES     = 1'b0,
        MODE_REINHARD = 1'b1
    } tm_mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(1);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    typedef logic [IN_W-1:0]     chan_in_t;
    typedef logic [OUT_W-1:0]    chan_t;
    typedef logic [DIV_W-1:0]    div_t;
    typedef logic [OUT_FRAC-1:0] quo_t;

    localparam chan_t ONE_OUT = chan_t'(1) << OUT_FRAC;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pix_out_t;

    // Lane to output stage: result and its valid
    typedef struct packed {
        logic     valid;
        pix_out_t pix;
    } merge_in_t;

endpackage

// ===== hdl/ht_if.sv =====
interface ht_pix_in_if import ht_pkg::*; ();
    logic     valid;
    logic     ready;
    chan_in_t red_in;
    chan_in_t green_in;
    chan_in_t blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface ht_pix_out_if import ht_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

interface ht_cfg_if import ht_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/hdr_tonemap.sv =====
// Channel  | Role | Carries
// pixel    | sink | red_in, green_in, blue_in (Q8.8)
// mapped   | src  | red_out, green_out, blue_out (Q1.12)
// cfg      | sink | index, data (register write, always ready)
//
// One pixel per clock while the skid entry is empty; a result passes through
// three front-end stages (factors, products, clamp detect), twelve stages of the
// restoring divider, one quotient bit each, then the output register.
// Reset gives ACES mode and unity exposure, and empties the pipe.
// Stalls: a skid entry behind the output register freezes the pipe only once it fills.
module hdr_tonemap import ht_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    ht_pix_in_if.sink     pixel,
    ht_pix_out_if.source  mapped,
    ht_cfg_if.sink        cfg
);

    tm_mode_t             mode_reg, mode_next;
    logic [GAIN_W-1:0]    gain_reg, gain_next;
    logic [NSTAGE-1:0]    valid_reg, valid_next;
    logic                 advance;
    merge_in_t            lanes;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        mode_next = mode_reg;
        gain_next = gain_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODE: mode_next = tm_mode_t'(cfg.data[0]);
                REG_GAIN: gain_next = cfg.data[GAIN_W-1:0];
                default:  ;
            endcase
        end
    end

    assign pixel.ready = advance;
    assign valid_next  = advance ? {valid_reg[NSTAGE-2:0], pixel.valid} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ACES;
            gain_reg  <= GAIN_RESET;
            valid_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            gain_reg  <= gain_next;
            valid_reg <= valid_next;
        end
    end

    ht_lane u_lane_red (
        .clk    (clk),
        .en     (advance),
        .x      (pixel.red_in),
        .mode   (mode_reg),
        .gain   (gain_reg),
        .result (lanes.pix.red)
    );

    ht_lane u_lane_green (
        .clk    (clk),
        .en     (advance),
        .x      (pixel.green_in),
        .mode   (mode_reg),
        .gain   (gain_reg),
        .result (lanes.pix.green)
    );

    ht_lane u_lane_blue (
        .clk    (clk),
        .en     (advance),
        .x      (pixel.blue_in),
        .mode   (mode_reg),
        .gain   (gain_reg),
        .result (lanes.pix.blue)
    );

    assign lanes.valid = valid_reg[NSTAGE-1];

    ht_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .lanes   (lanes),
        .advance (advance),
        .mapped  (mapped)
    );

endmodule

// ===== hdl/ht_div_step.sv =====
module ht_div_step import ht_pkg::*; (
    input  logic clk,
    input  logic en,
    input  div_t r_in,
    input  div_t den_in,
    input  quo_t q_in,
    input  logic sat_in,
    output div_t r,
    output div_t den,
    output quo_t q,
    output logic sat
);

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           ge;
    div_t           r_next;
    quo_t           q_next;

    div_t r_reg;
    div_t den_reg;
    quo_t q_reg;
    logic sat_reg;

    // One restoring step: remainder stays below the denominator
    always_comb
    begin
        shifted = {r_in, 1'b0};
        diff    = shifted - {1'b0, den_in};
        ge      = shifted >= {1'b0, den_in};
        r_next  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        q_next  = {q_in[OUT_FRAC-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            den_reg <= den_in;
            q_reg   <= q_next;
            sat_reg <= sat_in;
        end
    end

    assign r   = r_reg;
    assign den = den_reg;
    assign q   = q_reg;
    assign sat = sat_reg;

endmodule

// ===== hdl/ht_lane.sv =====
module ht_lane import ht_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  chan_in_t          x,
    input  tm_mode_t          mode,
    input  logic [GAIN_W-1:0] gain,
    output chan_t             result
);

    // Stage 1: polynomial factors and exposure product
    chan_in_t             x1_reg;
    tm_mode_t             mode1_reg;
    logic [A_W-1:0]       na1_reg, na1_next;
    logic [A_W-1:0]       da1_reg, da1_next;
    logic [RPROD_W-1:0]   rp1_reg, rp1_next;

    // Stage 2: ratio numerator and denominator
    div_t                 num2_reg, num2_next;
    div_t                 den2_reg, den2_next;
    logic [YW-1:0]        y_full;
    chan_in_t             y_sat;

    // Stage 3: clamp detect, start of division
    div_t                 r3_reg;
    div_t                 den3_reg;
    logic                 sat3_reg, sat3_next;

    div_t                 r_s   [OUT_FRAC+1];
    div_t                 den_s [OUT_FRAC+1];
    quo_t                 q_s   [OUT_FRAC+1];
    logic                 sat_s [OUT_FRAC+1];

    always_comb
    begin
        na1_next = A_W'(x) * A_W'(ACES_NA) + A_W'(ACES_NB);
        da1_next = A_W'(x) * A_W'(ACES_DA) + A_W'(ACES_DB);
        rp1_next = RPROD_W'(x) * RPROD_W'(gain);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= x;
            mode1_reg <= mode;
            na1_reg   <= na1_next;
            da1_reg   <= da1_next;
            rp1_reg   <= rp1_next;
        end
    end

    always_comb
    begin
        y_full = rp1_reg[RPROD_W-1:IN_FRAC];
        y_sat  = (y_full > YW'({IN_W{1'b1}})) ? {IN_W{1'b1}} : y_full[IN_W-1:0];
        case (mode1_reg)
            MODE_ACES:
            begin
                num2_next = DIV_W'(x1_reg) * DIV_W'(na1_reg);
                den2_next = DIV_W'(x1_reg) * DIV_W'(da1_reg) + DIV_W'(ACES_DC);
            end
            MODE_REINHARD:
            begin
                // y / (1 + y) with 1.0 = 1 << IN_FRAC
                num2_next = DIV_W'(y_sat);
                den2_next = DIV_W'(y_sat) + (DIV_W'(1) << IN_FRAC);
            end
            default:
            begin
                num2_next = '0;
                den2_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num2_reg <= num2_next;
            den2_reg <= den2_next;
        end
    end

    assign sat3_next = num2_reg >= den2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_reg   <= num2_reg;
            den3_reg <= den2_reg;
            sat3_reg <= sat3_next;
        end
    end

    assign r_s[0]   = r3_reg;
    assign den_s[0] = den3_reg;
    assign q_s[0]   = '0;
    assign sat_s[0] = sat3_reg;

    for (genvar i = 0; i < OUT_FRAC; i++)
    begin : g_step
        ht_div_step u_step (
            .clk    (clk),
            .en     (en),
            .r_in   (r_s[i]),
            .den_in (den_s[i]),
            .q_in   (q_s[i]),
            .sat_in (sat_s[i]),
            .r      (r_s[i+1]),
            .den    (den_s[i+1]),
            .q      (q_s[i+1]),
            .sat    (sat_s[i+1])
        );
    end

    // Final remainder and denominator are not needed past the last step
    assign result = sat_s[OUT_FRAC] ? ONE_OUT : {1'b0, q_s[OUT_FRAC]};

endmodule

// ===== hdl/ht_merge.sv =====
module ht_merge import ht_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  merge_in_t         lanes,
    output logic              advance,
    ht_pix_out_if.source      mapped
);

    // Output register plus one skid entry; the pipe moves whenever the skid is empty
    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    pix_out_t out_reg, out_next;
    pix_out_t skid_reg, skid_next;
    logic     take;
    logic     arrive;

    assign advance = !skid_valid_reg;
    assign take    = out_valid_reg && mapped.ready;
    assign arrive  = advance && lanes.valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = lanes.pix;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = lanes.pix;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign mapped.valid     = out_valid_reg;
    assign mapped.red_out   = out_reg.red;
    assign mapped.green_out = out_reg.green;
    assign mapped.blue_out  = out_reg.blue;

endmodule
